[design/imq_pkg.sv]
// Shared types and constants for the indexed min priority queue.
// No dependencies; used by imq_ctrl, imq_datapath and the top level by scoped names.
`default_nettype none
package imq_pkg;

    localparam int NUM_VALUES = 64;

    localparam logic [1:0] OP_PUSH     = 2'd0;
    localparam logic [1:0] OP_EXTRACT  = 2'd1;
    localparam logic [1:0] OP_DECREASE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_PRESENT   = 3'd3;
    localparam logic [2:0] ST_ABSENT    = 3'd4;
    localparam logic [2:0] ST_NOT_LOWER = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  item_value;
        logic [31:0] new_priority;
    } t_in;

    typedef struct packed {
        logic [5:0]  out_value;
        logic [31:0] out_priority;
        logic [2:0]  status;
        logic [6:0]  item_count;
    } t_out;

    typedef struct packed {
        logic [5:0]  value;
        logic [31:0] prio;
    } t_entry;

    // Datapath action for one cycle.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH,
        DP_EXT_ROOT,
        DP_EXT_LAST,
        DP_DEC_POS,
        DP_UP_RD,
        DP_UP_MOVE,
        DP_PLACE,
        DP_DN_RDL,
        DP_DN_SAVEL,
        DP_DN_MOVE,
        DP_RESP
    } t_act;

    typedef struct packed {
        t_act       act;
        logic [2:0] st;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       present;
        logic       empty;
        logic       last_one;
        logic       not_lower;
        logic       idx_zero;
        logic       up_swap;
        logic       dn_end;
        logic       dn_swap;
        logic       out_busy;
    } t_flags;

endpackage
`default_nettype wire

[design/imq_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module imq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[design/imq_datapath.sv]
// Heap datapath: heap and position RAMs, presence bits, count, sift registers.
// Depends on imq_pkg and imq_ram.
`default_nettype none
module imq_datapath #(
    parameter int EFF = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire imq_pkg::t_in   i_in_data,
    input  wire imq_pkg::t_cmd  i_cmd,
    input  wire logic           i_out_ready,
    output imq_pkg::t_flags     o_flags,
    output logic                o_out_valid,
    output imq_pkg::t_out       o_out_data
);
    localparam int IW = $clog2(EFF);
    localparam int CW = $clog2(EFF + 1);

    logic [CW-1:0]               r_cnt;
    logic [imq_pkg::NUM_VALUES-1:0] r_valid;
    logic [IW-1:0]               r_idx;
    imq_pkg::t_entry             r_x;
    logic [1:0]                  r_op;
    imq_pkg::t_entry             r_sav;
    logic [IW-1:0]               r_sav_idx;
    logic                        r_has_r;
    logic [5:0]                  r_ov;
    logic [31:0]                 r_opr;
    logic                        r_out_valid;
    imq_pkg::t_out               r_out;

    logic                        heap_we, heap_re, pos_we, pos_re;
    logic [IW-1:0]               heap_waddr, heap_raddr, pos_wdata;
    imq_pkg::t_entry             heap_wdata, heap_rdata;
    logic [5:0]                  pos_waddr, pos_raddr;
    logic [IW-1:0]               pos_rdata;

    logic [IW+1:0]               lc_ext, rc_ext, cnt_ext;
    logic [IW-1:0]               parent;
    logic                        pick_r;
    imq_pkg::t_entry             cand;
    logic [IW-1:0]               cand_idx;

    assign lc_ext   = {1'b0, r_idx, 1'b1};
    assign rc_ext   = lc_ext + (IW+2)'(1);
    assign cnt_ext  = (IW+2)'(r_cnt);
    assign parent   = (r_idx - IW'(1)) >> 1;
    assign pick_r   = r_has_r && (heap_rdata.prio < r_sav.prio);
    assign cand     = pick_r ? heap_rdata : r_sav;
    assign cand_idx = pick_r ? (r_sav_idx + IW'(1)) : r_sav_idx;

    always_comb begin
        o_flags.op        = r_op;
        o_flags.full      = (r_cnt == CW'(EFF));
        o_flags.present   = r_valid[r_x.value];
        o_flags.empty     = (r_cnt == '0);
        o_flags.last_one  = (r_cnt == CW'(1));
        o_flags.not_lower = (r_x.prio >= heap_rdata.prio);
        o_flags.idx_zero  = (r_idx == '0);
        o_flags.up_swap   = (heap_rdata.prio > r_x.prio);
        o_flags.dn_end    = (lc_ext >= cnt_ext);
        o_flags.dn_swap   = (cand.prio < r_x.prio);
        o_flags.out_busy  = r_out_valid && !i_out_ready;
    end

    always_comb begin
        heap_we    = 1'b0;
        heap_waddr = r_idx;
        heap_wdata = r_x;
        heap_re    = 1'b0;
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = r_x.value;
        pos_wdata  = r_idx;
        pos_re     = 1'b0;
        pos_raddr  = i_in_data.item_value;
        unique case (i_cmd.act)
            imq_pkg::DP_LOAD: begin
                pos_re  = 1'b1;
                heap_re = 1'b1;
            end
            imq_pkg::DP_EXT_ROOT: begin
                heap_re    = 1'b1;
                heap_raddr = IW'(r_cnt - CW'(1));
            end
            imq_pkg::DP_DEC_POS: begin
                heap_re    = 1'b1;
                heap_raddr = pos_rdata;
            end
            imq_pkg::DP_UP_RD: begin
                heap_re    = 1'b1;
                heap_raddr = parent;
            end
            imq_pkg::DP_UP_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = heap_rdata;
                pos_we     = 1'b1;
                pos_waddr  = heap_rdata.value;
            end
            imq_pkg::DP_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            imq_pkg::DP_DN_RDL: begin
                heap_re    = 1'b1;
                heap_raddr = lc_ext[IW-1:0];
            end
            imq_pkg::DP_DN_SAVEL: begin
                heap_re    = (rc_ext < cnt_ext);
                heap_raddr = rc_ext[IW-1:0];
            end
            imq_pkg::DP_DN_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = cand;
                pos_we     = 1'b1;
                pos_waddr  = cand.value;
            end
            default: begin
            end
        endcase
    end

    imq_ram #(.WIDTH($bits(imq_pkg::t_entry)), .DEPTH(EFF)) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_re    (heap_re),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    imq_ram #(.WIDTH(IW), .DEPTH(imq_pkg::NUM_VALUES)) u_pos (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // Control state: count, presence bits, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.act == imq_pkg::DP_RESP) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.act)
                imq_pkg::DP_PUSH: begin
                    r_cnt            <= r_cnt + CW'(1);
                    r_valid[r_x.value] <= 1'b1;
                end
                imq_pkg::DP_EXT_ROOT: begin
                    r_cnt                     <= r_cnt - CW'(1);
                    r_valid[heap_rdata.value] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.act)
            imq_pkg::DP_LOAD: begin
                r_op  <= i_in_data.operation;
                r_x   <= {i_in_data.item_value, i_in_data.new_priority};
                r_ov  <= i_in_data.item_value;
                r_opr <= '0;
            end
            imq_pkg::DP_PUSH:     r_idx <= IW'(r_cnt);
            imq_pkg::DP_EXT_ROOT: begin
                r_ov  <= heap_rdata.value;
                r_opr <= heap_rdata.prio;
            end
            imq_pkg::DP_EXT_LAST: begin
                r_x   <= heap_rdata;
                r_idx <= '0;
            end
            imq_pkg::DP_DEC_POS:  r_idx <= pos_rdata;
            imq_pkg::DP_UP_MOVE:  r_idx <= parent;
            imq_pkg::DP_DN_SAVEL: begin
                r_sav     <= heap_rdata;
                r_sav_idx <= lc_ext[IW-1:0];
                r_has_r   <= (rc_ext < cnt_ext);
            end
            imq_pkg::DP_DN_MOVE:  r_idx <= cand_idx;
            imq_pkg::DP_RESP: begin
                r_out.out_value    <= (i_cmd.st == imq_pkg::ST_EMPTY) ? 6'd0 : r_ov;
                r_out.out_priority <= r_opr;
                r_out.status       <= i_cmd.st;
                r_out.item_count   <= 7'(r_cnt);
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

[design/imq_ctrl.sv]
// Sequencer for the min priority queue: decodes an operation and steps the sift.
// Depends on imq_pkg.
`default_nettype none
module imq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire imq_pkg::t_flags i_flags,
    output logic                 o_in_ready,
    output imq_pkg::t_cmd        o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECODE   = 10'b0000000010,
        S_EXT_LAST = 10'b0000000100,
        S_DEC_CMP  = 10'b0000001000,
        S_UP       = 10'b0000010000,
        S_UP_CMP   = 10'b0000100000,
        S_DN       = 10'b0001000000,
        S_DN_L     = 10'b0010000000,
        S_DN_CMP   = 10'b0100000000,
        S_RESP     = 10'b1000000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_st, n_st;

    always_comb begin
        n_state   = r_state;
        n_st      = r_st;
        o_cmd.act = imq_pkg::DP_NOP;
        o_cmd.st  = r_st;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.act = imq_pkg::DP_LOAD;
                    n_st      = imq_pkg::ST_OK;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESP;
                unique case (i_flags.op)
                    imq_pkg::OP_PUSH: begin
                        if (i_flags.full) begin
                            n_st = imq_pkg::ST_FULL;
                        end else if (i_flags.present) begin
                            n_st = imq_pkg::ST_PRESENT;
                        end else begin
                            o_cmd.act = imq_pkg::DP_PUSH;
                            n_state   = S_UP;
                        end
                    end
                    imq_pkg::OP_EXTRACT: begin
                        if (i_flags.empty) begin
                            n_st = imq_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.act = imq_pkg::DP_EXT_ROOT;
                            if (!i_flags.last_one) begin
                                n_state = S_EXT_LAST;
                            end
                        end
                    end
                    imq_pkg::OP_DECREASE: begin
                        if (!i_flags.present) begin
                            n_st = imq_pkg::ST_ABSENT;
                        end else begin
                            o_cmd.act = imq_pkg::DP_DEC_POS;
                            n_state   = S_DEC_CMP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EXT_LAST: begin
                o_cmd.act = imq_pkg::DP_EXT_LAST;
                n_state   = S_DN;
            end
            S_DEC_CMP: begin
                if (i_flags.not_lower) begin
                    n_st    = imq_pkg::ST_NOT_LOWER;
                    n_state = S_RESP;
                end else begin
                    n_state = S_UP;
                end
            end
            S_UP: begin
                if (i_flags.idx_zero) begin
                    o_cmd.act = imq_pkg::DP_PLACE;
                    n_state   = S_RESP;
                end else begin
                    o_cmd.act = imq_pkg::DP_UP_RD;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_flags.up_swap) begin
                    o_cmd.act = imq_pkg::DP_UP_MOVE;
                    n_state   = S_UP;
                end else begin
                    o_cmd.act = imq_pkg::DP_PLACE;
                    n_state   = S_RESP;
                end
            end
            S_DN: begin
                if (i_flags.dn_end) begin
                    o_cmd.act = imq_pkg::DP_PLACE;
                    n_state   = S_RESP;
                end else begin
                    o_cmd.act = imq_pkg::DP_DN_RDL;
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                o_cmd.act = imq_pkg::DP_DN_SAVEL;
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_flags.dn_swap) begin
                    o_cmd.act = imq_pkg::DP_DN_MOVE;
                    n_state   = S_DN;
                end else begin
                    o_cmd.act = imq_pkg::DP_PLACE;
                    n_state   = S_RESP;
                end
            end
            S_RESP: begin
                if (!i_flags.out_busy) begin
                    o_cmd.act = imq_pkg::DP_RESP;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= imq_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

[design/indexed_min_priority_queue.sv]
// Top level of the indexed min priority queue: sequencer plus heap datapath.
// Depends on imq_pkg, imq_ctrl, imq_datapath (and imq_ram through it).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one operation
//   beat: push, extract minimum or decrease priority, with value and priority.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//   beat per operation: value, priority, status code and entry count after it.
//   Capacity is min(CAPACITY, 64), since only 64 distinct values exist.
//   Timing: an operation holds the block from its accepting cycle until the
//   edge that raises o_out_valid and returns to idle. After load and decode,
//   a push or decrease walks sift-up (read the parent, compare, move) and an
//   extract walks sift-down (read the left child, then the right, since both
//   share the single heap read port, then compare and move); a walk ends
//   with a placement step before the response.
//   Throughput is one operation at a time; o_in_ready is high only in idle.
//   A finished beat sits in the output register, so the next operation is
//   taken while it waits; if the receiver stalls, the following operation
//   holds at its end until the register frees, then the queue drains.
//   Reset (synchronous, active low) empties the queue and marks every value
//   absent at once; no clearing pass is needed.
`default_nettype none
module indexed_min_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire imq_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output imq_pkg::t_out      o_out_data
);
    // Clamp the heap depth to the number of distinct values.
    localparam int EFF = (CAPACITY > imq_pkg::NUM_VALUES) ? imq_pkg::NUM_VALUES : CAPACITY;

    imq_pkg::t_cmd   cmd;
    imq_pkg::t_flags flags;

    imq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    imq_datapath #(.EFF(EFF)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

[tb/indexed_min_priority_queue_tb.sv]
// Self-checking testbench for the indexed min priority queue.
// Depends on imq_pkg and indexed_min_priority_queue; a built-in heap model predicts each beat.
`default_nettype none
module indexed_min_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 5000;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    imq_pkg::t_in    in_data;
    logic            out_valid;
    logic            out_ready;
    imq_pkg::t_out   out_data;

    indexed_min_priority_queue #(.CAPACITY(DEPTH)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    // Heap mirror: slot arrays, value-to-slot map, entry count.
    logic [5:0]  heap_val [DEPTH];
    logic [31:0] heap_pri [DEPTH];
    int          slot_of  [64];
    int          heap_size;

    imq_pkg::t_out pending_results[$];
    int            mismatches;
    int            beats_in;
    int            beats_out;
    int            idle_cycles;
    int            status_seen [6];

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void swap_slots(int a, int b);
        logic [5:0]  tv;
        logic [31:0] tp;
        tv = heap_val[a]; tp = heap_pri[a];
        heap_val[a] = heap_val[b]; heap_pri[a] = heap_pri[b];
        heap_val[b] = tv; heap_pri[b] = tp;
        slot_of[heap_val[a]] = a;
        slot_of[heap_val[b]] = b;
    endfunction

    function automatic void bubble_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (heap_pri[p] <= heap_pri[i]) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down(int i);
        int l;
        int m;
        forever begin
            l = 2 * i + 1;
            if (l >= heap_size) break;
            m = l;
            if (l + 1 < heap_size && heap_pri[l + 1] < heap_pri[l]) m = l + 1;
            if (heap_pri[m] >= heap_pri[i]) break;
            swap_slots(i, m);
            i = m;
        end
    endfunction

    // Apply one operation to the mirror and return the beat it yields.
    function automatic imq_pkg::t_out apply_heap_op(imq_pkg::t_in op);
        imq_pkg::t_out r;
        int            i;
        r = '0;
        r.out_value = op.item_value;
        r.status = imq_pkg::ST_OK;
        case (op.operation)
            imq_pkg::OP_PUSH: begin
                if (heap_size >= DEPTH) r.status = imq_pkg::ST_FULL;
                else if (slot_of[op.item_value] < heap_size) r.status = imq_pkg::ST_PRESENT;
                else begin
                    i = heap_size;
                    heap_val[i] = op.item_value;
                    heap_pri[i] = op.new_priority;
                    slot_of[op.item_value] = i;
                    heap_size++;
                    bubble_up(i);
                end
            end
            imq_pkg::OP_EXTRACT: begin
                if (heap_size == 0) begin
                    r.status = imq_pkg::ST_EMPTY;
                    r.out_value = '0;
                end else begin
                    r.out_value = heap_val[0];
                    r.out_priority = heap_pri[0];
                    slot_of[heap_val[0]] = DEPTH;
                    heap_size--;
                    if (heap_size > 0) begin
                        heap_val[0] = heap_val[heap_size];
                        heap_pri[0] = heap_pri[heap_size];
                        slot_of[heap_val[0]] = 0;
                        bubble_down(0);
                    end
                end
            end
            imq_pkg::OP_DECREASE: begin
                if (slot_of[op.item_value] >= heap_size) r.status = imq_pkg::ST_ABSENT;
                else begin
                    i = slot_of[op.item_value];
                    if (op.new_priority >= heap_pri[i]) r.status = imq_pkg::ST_NOT_LOWER;
                    else begin
                        heap_pri[i] = op.new_priority;
                        bubble_up(i);
                    end
                end
            end
            default: ;
        endcase
        r.item_count = 7'(heap_size);
        return r;
    endfunction

    // Output side: random stall per beat, compare with the oldest expectation.
    initial begin
        int            wait_n;
        imq_pkg::t_out exp_beat;
        out_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            wait_n = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) wait_n = 0;
            // Hold ready on a zero wait; otherwise drop it for the drawn gap.
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk iff out_valid);
            beats_out++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected beat %p", out_data);
            end else begin
                exp_beat = pending_results.pop_front();
                if (out_data !== exp_beat) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: beat %0d expected val=%0d pri=%h st=%0d cnt=%0d",
                                 beats_out, exp_beat.out_value, exp_beat.out_priority,
                                 exp_beat.status, exp_beat.item_count);
                        $display("       got val=%0d pri=%h st=%0d cnt=%0d",
                                 out_data.out_value, out_data.out_priority,
                                 out_data.status, out_data.item_count);
                    end
                end else begin
                    status_seen[exp_beat.status]++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge clk iff idle_cycles >= STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Send one operation beat after a random gap; predict its result on accept.
    task automatic send_op(imq_pkg::t_in op);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= op;
        in_valid <= 1'b1;
        @(posedge clk iff in_ready);
        pending_results.push_back(apply_heap_op(op));
        beats_in++;
    endtask

    // Like send_op but with no gap; also check the model's prediction against a typed-in status and count.
    task automatic send_known(imq_pkg::t_in op, logic [2:0] st, logic [6:0] cnt);
        imq_pkg::t_out pred;
        in_data  <= op;
        in_valid <= 1'b1;
        @(posedge clk iff in_ready);
        pred = apply_heap_op(op);
        if (pred.status !== st || pred.item_count !== cnt) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: directed row predicts st=%0d cnt=%0d, table says st=%0d cnt=%0d",
                         pred.status, pred.item_count, st, cnt);
        end
        pending_results.push_back(pred);
        beats_in++;
    endtask

    function automatic imq_pkg::t_in mk(logic [1:0] o, logic [5:0] v, logic [31:0] p);
        imq_pkg::t_in t;
        t.operation = o;
        t.item_value = v;
        t.new_priority = p;
        return t;
    endfunction

    // Directed table: operation, value, priority, typed status (or unchecked), count.
    typedef struct {
        imq_pkg::t_in op;
        logic         known;
        logic [2:0]   st;
        logic [6:0]   cnt;
    } t_row;

    initial begin
        t_row         rows[$];
        imq_pkg::t_in op;
        int           r;
        int           n;
        int           v;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        idle_cycles = 0;
        heap_size = 0;
        foreach (slot_of[k]) slot_of[k] = DEPTH;
        foreach (status_seen[k]) status_seen[k] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty extract, absent decrease, extremes, duplicate push, not-lower,
        // equal priorities, unused code three.
        rows.push_back('{mk(imq_pkg::OP_EXTRACT, 6'd17, 32'h0), 1, imq_pkg::ST_EMPTY, 0});
        rows.push_back('{mk(imq_pkg::OP_DECREASE, 6'd5, 32'h0), 1, imq_pkg::ST_ABSENT, 0});
        rows.push_back('{mk(imq_pkg::OP_PUSH, 6'd63, 32'hFFFF_FFFF), 1, imq_pkg::ST_OK, 1});
        rows.push_back('{mk(imq_pkg::OP_PUSH, 6'd0, 32'h0), 1, imq_pkg::ST_OK, 2});
        rows.push_back('{mk(imq_pkg::OP_PUSH, 6'd63, 32'h5), 1, imq_pkg::ST_PRESENT, 2});
        rows.push_back('{mk(imq_pkg::OP_DECREASE, 6'd0, 32'h0), 1, imq_pkg::ST_NOT_LOWER, 2});
        rows.push_back('{mk(imq_pkg::OP_DECREASE, 6'd63, 32'hFFFF_FFFF), 1,
                         imq_pkg::ST_NOT_LOWER, 2});
        rows.push_back('{mk(imq_pkg::OP_PUSH, 6'd21, 32'h8000_0000), 0, 0, 0});
        rows.push_back('{mk(imq_pkg::OP_PUSH, 6'd42, 32'h8000_0000), 0, 0, 0});
        rows.push_back('{mk(imq_pkg::OP_PUSH, 6'd7, 32'h8000_0000), 0, 0, 0});
        rows.push_back('{mk(imq_pkg::OP_DECREASE, 6'd63, 32'h0), 0, 0, 0});
        rows.push_back('{mk(2'd3, 6'd44, 32'hDEAD_BEEF), 1, imq_pkg::ST_OK, 5});
        rows.push_back('{mk(imq_pkg::OP_EXTRACT, 6'd0, 32'h0), 0, 0, 0});
        rows.push_back('{mk(imq_pkg::OP_EXTRACT, 6'd0, 32'h0), 0, 0, 0});
        rows.push_back('{mk(imq_pkg::OP_EXTRACT, 6'd0, 32'h0), 0, 0, 0});
        rows.push_back('{mk(imq_pkg::OP_EXTRACT, 6'd0, 32'h0), 0, 0, 0});
        rows.push_back('{mk(imq_pkg::OP_EXTRACT, 6'd0, 32'h0), 0, 0, 0});
        rows.push_back('{mk(imq_pkg::OP_EXTRACT, 6'd0, 32'h0), 1, imq_pkg::ST_EMPTY, 0});
        for (r = 0; r < rows.size(); r++) begin
            if (rows[r].known) send_known(rows[r].op, rows[r].st, rows[r].cnt);
            else send_op(rows[r].op);
        end

        // Fill to capacity, then hit the full case.
        for (v = 0; v < 64; v++) send_op(mk(imq_pkg::OP_PUSH, 6'(v), $urandom()));
        send_known(mk(imq_pkg::OP_PUSH, 6'd9, 32'h1), imq_pkg::ST_FULL, 7'd64);
        in_valid <= 1'b0;

        // Pause until every expected beat has drained.
        @(posedge clk iff pending_results.size() == 0);

        // Random part: biased toward valid operations on present/absent values.
        for (n = 0; n < 420; n++) begin
            r = $urandom_range(0, 99);
            op.new_priority = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) :
                              $urandom();
            op.item_value = 6'($urandom_range(0, 63));
            if (r < 40) begin
                op.operation = imq_pkg::OP_PUSH;
            end else if (r < 70) begin
                op.operation = imq_pkg::OP_EXTRACT;
            end else if (r < 97) begin
                op.operation = imq_pkg::OP_DECREASE;
                // Mostly pick a present value with a lower key.
                if (heap_size > 0 && $urandom_range(0, 3) != 0) begin
                    op.item_value = heap_val[$urandom_range(0, heap_size - 1)];
                    if ($urandom_range(0, 4) != 0 && heap_pri[slot_of[op.item_value]] != 0)
                        op.new_priority = $urandom_range(0, heap_pri[slot_of[op.item_value]] - 1);
                end
            end else begin
                op.operation = 2'd3;
            end
            send_op(op);
        end
        in_valid <= 1'b0;

        @(posedge clk iff pending_results.size() == 0);
        repeat (40) @(posedge clk);
        $display("Covered %0d operations and %0d result beats under random stalls on both sides,",
                 beats_in, beats_out);
        $display("matched per status ok/empty/full/present/absent/not-lower: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
